// ===== rtl/lcr_pkg.sv =====
// ----------------------------------------------------------------------------
// lcr_pkg
// Shared types and constants of the load-cell converter reader.
// ----------------------------------------------------------------------------
package lcr_pkg;

   localparam int LCR_SAMPLE_BITS = 24;   // bits clocked out of the converter
   localparam int LCR_OUT_W       = 24;   // width of raw_value and weight
   localparam int LCR_GAP_W       = 16;   // calibration divisor, Q8.8
   localparam int LCR_FRAC_BITS   = 8;    // fraction bits of the divisor

   localparam logic [LCR_GAP_W-1:0] LCR_GAP_RESET = 16'd64640;  // 252.5

   localparam logic [1:0] FUNC_TICK  = 2'd0;
   localparam logic [1:0] FUNC_TARE  = 2'd1;
   localparam logic [1:0] FUNC_WEIGH = 2'd2;

   // converter frame phase, advanced at most once per tick
   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_WAIT  = 3'd1,
      PH_HIGH  = 3'd2,
      PH_LOW   = 3'd3,
      PH_XHIGH = 3'd4,
      PH_XLOW  = 3'd5
   } phase_type;

   // handshake controller states
   typedef enum logic [1:0] {
      CS_READY  = 2'd0,
      CS_DIVIDE = 2'd1,
      CS_RESULT = 2'd2
   } ctrl_state_type;

   typedef struct packed {
      logic step;        // tick accepted, advance the frame
      logic div_start;   // launch the weight division
      logic div_commit;  // write the quotient to the weight
   } lcr_cmd_type;

   typedef struct packed {
      logic div_needed;  // this tick completes a weigh frame above tare
      logic div_done;    // quotient is ready
   } lcr_status_type;

endpackage

// ===== rtl/lcr_channels.sv =====
// ----------------------------------------------------------------------------
// lcr channels
// Valid/ready channels for ticks in and per-tick results out.
// ----------------------------------------------------------------------------
interface lcr_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic       dout;

   modport source (output valid, output func, output dout, input ready);
   modport sink   (input valid, input func, input dout, output ready);
endinterface

interface lcr_rsp_if;
   logic        valid;
   logic        ready;
   logic        sck;
   logic        busy_res;
   logic        done_res;
   logic [23:0] raw_value;
   logic [23:0] weight;
   logic        weight_updated;

   modport source (output valid, output sck, output busy_res, output done_res,
                   output raw_value, output weight, output weight_updated,
                   input ready);
   modport sink   (input valid, input sck, input busy_res, input done_res,
                   input raw_value, input weight, input weight_updated,
                   output ready);
endinterface

// ===== rtl/lcr_divider.sv =====
// ----------------------------------------------------------------------------
// lcr_divider
// Restoring divider, one quotient bit per cycle, for the weight scaling.
// ----------------------------------------------------------------------------
module lcr_divider
   import lcr_pkg::*;
#(
   parameter int DIVIDEND_W = LCR_SAMPLE_BITS + LCR_FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [LCR_GAP_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [DIVIDEND_W-1:0] num_ff, num_in;
   logic [LCR_GAP_W-1:0]  rem_ff, rem_in;
   logic [LCR_GAP_W-1:0]  den_ff, den_in;

   logic [LCR_GAP_W:0]    rem_shift;
   logic [LCR_GAP_W:0]    rem_sel;
   logic                  fits;
   logic                  last;

   assign rem_shift = {rem_ff, num_ff[DIVIDEND_W-1]};
   assign fits      = rem_shift >= {1'b0, den_ff};
   assign rem_sel   = fits ? (rem_shift - {1'b0, den_ff}) : rem_shift;
   assign last      = count_ff == CNT_W'(DIVIDEND_W - 1);

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         num_in   = dividend;
         rem_in   = '0;
         den_in   = divisor;
      end else if (busy_ff) begin
         // quotient bits enter at the bottom as dividend bits leave the top
         num_in   = {num_ff[DIVIDEND_W-2:0], fits};
         rem_in   = rem_sel[LCR_GAP_W-1:0];
         count_in = count_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = num_ff;

endmodule

// ===== rtl/lcr_datapath.sv =====
// ----------------------------------------------------------------------------
// lcr_datapath
// Frame sequencing of the converter lines, sample shift register, tare and
// weight registers, calibration register and result fields.
// ----------------------------------------------------------------------------
module lcr_datapath
   import lcr_pkg::*;
#(
   parameter int SAMPLE_BITS = LCR_SAMPLE_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lcr_cmd_type          cmd,
   output lcr_status_type       status,
   input  logic [1:0]           req_func,
   input  logic                 req_dout,
   input  logic                 csr_we,
   input  logic [LCR_GAP_W-1:0] csr_wdata,
   output logic                 rsp_sck,
   output logic                 rsp_busy_res,
   output logic                 rsp_done_res,
   output logic [LCR_OUT_W-1:0] rsp_raw_value,
   output logic [LCR_OUT_W-1:0] rsp_weight,
   output logic                 rsp_weight_updated
);

   localparam int COUNT_W    = $clog2(SAMPLE_BITS + 1);
   localparam int DIVIDEND_W = SAMPLE_BITS + LCR_FRAC_BITS;

   phase_type              phase_ff, phase_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [SAMPLE_BITS-1:0] shift_ff, shift_in;
   logic                   is_tare_ff, is_tare_in;
   logic [SAMPLE_BITS-1:0] tare_ff, tare_in;
   logic [SAMPLE_BITS-1:0] last_raw_ff, last_raw_in;
   logic [LCR_OUT_W-1:0]   weight_ff, weight_in;
   logic [LCR_GAP_W-1:0]   gap_ff;
   logic                   sck_ff, sck_in;
   logic                   done_ff, done_in;
   logic                   upd_ff, upd_in;

   logic [SAMPLE_BITS-1:0]           raw;
   logic [SAMPLE_BITS-1:0]           delta;
   logic [COUNT_W-1:0]               count_inc;
   logic                             div_done;
   logic [DIVIDEND_W-1:0]            quotient;
   logic [DIVIDEND_W+LCR_OUT_W-1:0]  quot_wide;
   logic                             quot_sat;
   logic [SAMPLE_BITS+LCR_OUT_W-1:0] raw_wide;

   // offset binary: flip the sign bit
   assign raw       = {~shift_ff[SAMPLE_BITS-1], shift_ff[SAMPLE_BITS-2:0]};
   assign delta     = raw - tare_ff;
   assign count_inc = count_ff + 1'b1;

   assign status.div_needed = (phase_ff == PH_XLOW) && !is_tare_ff && (raw > tare_ff);
   assign status.div_done   = div_done;

   lcr_divider #(
      .DIVIDEND_W (DIVIDEND_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend ({delta, {LCR_FRAC_BITS{1'b0}}}),
      .divisor  (gap_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign quot_wide = {{LCR_OUT_W{1'b0}}, quotient};
   assign quot_sat  = |quot_wide[DIVIDEND_W+LCR_OUT_W-1:LCR_OUT_W];

   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      shift_in    = shift_ff;
      is_tare_in  = is_tare_ff;
      tare_in     = tare_ff;
      last_raw_in = last_raw_ff;
      weight_in   = weight_ff;
      sck_in      = sck_ff;
      done_in     = done_ff;
      upd_in      = upd_ff;
      if (cmd.step) begin
         sck_in  = 1'b0;
         done_in = 1'b0;
         upd_in  = 1'b0;
         case (phase_ff)
            PH_IDLE: begin
               if (req_func == FUNC_TARE || req_func == FUNC_WEIGH) begin
                  is_tare_in = req_func == FUNC_TARE;
                  count_in   = '0;
                  shift_in   = '0;
                  phase_in   = PH_WAIT;
               end
            end
            PH_WAIT: begin
               // converter pulls the data line low when a conversion is ready
               if (!req_dout) begin
                  phase_in = PH_HIGH;
               end
            end
            PH_HIGH: begin
               sck_in   = 1'b1;
               shift_in = {shift_ff[SAMPLE_BITS-2:0], 1'b0};
               phase_in = PH_LOW;
            end
            PH_LOW: begin
               shift_in = {shift_ff[SAMPLE_BITS-1:1], shift_ff[0] | req_dout};
               count_in = count_inc;
               phase_in = (count_inc >= COUNT_W'(SAMPLE_BITS)) ? PH_XHIGH : PH_HIGH;
            end
            PH_XHIGH: begin
               // extra pulse selects gain 128 for the next conversion
               sck_in   = 1'b1;
               phase_in = PH_XLOW;
            end
            PH_XLOW: begin
               if (is_tare_ff) begin
                  tare_in = raw;
               end else begin
                  last_raw_in = raw;
                  upd_in      = status.div_needed;
               end
               done_in  = 1'b1;
               count_in = '0;
               phase_in = PH_IDLE;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
      if (cmd.div_commit) begin
         weight_in = (quot_sat || gap_ff == '0) ? '1 : quot_wide[LCR_OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         count_ff    <= '0;
         shift_ff    <= '0;
         is_tare_ff  <= 1'b0;
         tare_ff     <= '0;
         last_raw_ff <= '0;
         weight_ff   <= '0;
         gap_ff      <= LCR_GAP_RESET;
         sck_ff      <= 1'b0;
         done_ff     <= 1'b0;
         upd_ff      <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         shift_ff    <= shift_in;
         is_tare_ff  <= is_tare_in;
         tare_ff     <= tare_in;
         last_raw_ff <= last_raw_in;
         weight_ff   <= weight_in;
         sck_ff      <= sck_in;
         done_ff     <= done_in;
         upd_ff      <= upd_in;
         if (csr_we) begin
            gap_ff <= csr_wdata;
         end
      end
   end

   assign raw_wide = {{LCR_OUT_W{1'b0}}, last_raw_ff};

   assign rsp_sck            = sck_ff;
   assign rsp_busy_res       = phase_ff != PH_IDLE;
   assign rsp_done_res       = done_ff;
   assign rsp_raw_value      = raw_wide[LCR_OUT_W-1:0];
   assign rsp_weight         = weight_ff;
   assign rsp_weight_updated = upd_ff;

endmodule

// ===== rtl/lcr_ctrl.sv =====
// ----------------------------------------------------------------------------
// lcr_ctrl
// Handshake controller: takes one tick, waits for the division when a
// weigh frame completes above the tare, then holds the result until it is taken.
// ----------------------------------------------------------------------------
module lcr_ctrl
   import lcr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output lcr_cmd_type    cmd,
   input  lcr_status_type status
);

   ctrl_state_type state_ff, state_in;
   logic           take;

   assign take = req_valid && (state_ff == CS_READY);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CS_READY: begin
            if (take) begin
               state_in = status.div_needed ? CS_DIVIDE : CS_RESULT;
            end
         end
         CS_DIVIDE: begin
            if (status.div_done) begin
               state_in = CS_RESULT;
            end
         end
         CS_RESULT: begin
            if (rsp_ready) begin
               state_in = CS_READY;
            end
         end
         default: begin
            state_in = CS_READY;
         end
      endcase
   end

   always_comb begin
      req_ready      = 1'b0;
      rsp_valid      = 1'b0;
      cmd.step       = 1'b0;
      cmd.div_start  = 1'b0;
      cmd.div_commit = 1'b0;
      case (state_ff)
         CS_READY: begin
            req_ready     = 1'b1;
            cmd.step      = take;
            cmd.div_start = take && status.div_needed;
         end
         CS_DIVIDE: begin
            cmd.div_commit = status.div_done;
         end
         CS_RESULT: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_READY;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/load_cell_adc_reader_tare_scale.sv =====
// ----------------------------------------------------------------------------
// load_cell_adc_reader_tare_scale
// Two-wire load-cell converter reader with tare and calibrated scaling.
// ----------------------------------------------------------------------------
// Each transfer on req_chan is one half-bit tick of the converter interface:
// func starts a tare or weigh frame, dout is the sampled data line. Every
// tick gives exactly one transfer on rsp_chan with the clock level to drive,
// busy/done flags, the last raw reading and the last weight.
// A tick is taken while req_chan.ready is high; the result of an ordinary
// tick is registered and offered on rsp_chan in the cycle after. The tick
// that completes a weigh frame above the tare runs the restoring divider,
// one quotient bit per cycle over SAMPLE_BITS + 8 bits, and its result
// is offered once the quotient has been written to the weight.
// One tick is in flight at a time: req_chan.ready is low from the transfer
// until the result has been taken, and a stalled rsp_chan holds its result.
// csr_wdata is written to the Q8.8 divisor at any edge with csr_we high;
// write it only while no tick is pending.
// Reset clears the frame state, tare, raw reading and weight, and loads the
// divisor with 252.5.
// ----------------------------------------------------------------------------
module load_cell_adc_reader_tare_scale
   import lcr_pkg::*;
#(
   parameter int SAMPLE_BITS = LCR_SAMPLE_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   lcr_req_if.sink              req_chan,
   lcr_rsp_if.source            rsp_chan,
   input  logic                 csr_we,
   input  logic [LCR_GAP_W-1:0] csr_wdata
);

   lcr_cmd_type    cmd;
   lcr_status_type status;

   lcr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   lcr_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_func           (req_chan.func),
      .req_dout           (req_chan.dout),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata),
      .rsp_sck            (rsp_chan.sck),
      .rsp_busy_res       (rsp_chan.busy_res),
      .rsp_done_res       (rsp_chan.done_res),
      .rsp_raw_value      (rsp_chan.raw_value),
      .rsp_weight         (rsp_chan.weight),
      .rsp_weight_updated (rsp_chan.weight_updated)
   );

endmodule

// ===== rtl/lcr_checker.sv =====
// ----------------------------------------------------------------------------
// lcr_checker
// Port-level checks of the reader, bound to the top level.
// ----------------------------------------------------------------------------
module lcr_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic sck,
   input logic busy_res,
   input logic done_res,
   input logic weight_updated
);

   // one tick in flight: no new transfer while a result is pending
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_valid && req_ready && rsp_valid))
      else $error("tick taken while a result is pending");

   // a tick transfer is answered on the next cycle unless a division runs
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (rsp_valid || !req_ready))
      else $error("no result and ready after tick transfer");

   a_update_on_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && weight_updated) |-> done_res)
      else $error("weight update outside a frame completion");

   a_done_is_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && done_res) |-> (!busy_res && !sck))
      else $error("completion with busy or clock high");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped while stalled");

endmodule

bind load_cell_adc_reader_tare_scale lcr_checker u_lcr_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .sck            (rsp_chan.sck),
   .busy_res       (rsp_chan.busy_res),
   .done_res       (rsp_chan.done_res),
   .weight_updated (rsp_chan.weight_updated)
);

// ===== tb/load_cell_adc_reader_tare_scale_tb.sv =====
// ----------------------------------------------------------------------------
// load_cell_adc_reader_tare_scale_tb
// Drives converter ticks through whole tare and weigh frames with random
// data words, random hold-off on the data line and requests made while busy.
// A scoreboard tracks the frame phase, tare, raw reading and scaled weight
// and checks every result transfer. The divisor is rewritten between
// phases, including 1.0 and its maximum.
// ----------------------------------------------------------------------------
module load_cell_adc_reader_tare_scale_tb;
   import lcr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] FUNC_SPARE = 2'd3;   // unused code, acts as a plain tick
   localparam int TICKS_PER_PHASE   = 250;
   localparam int PHASE_COUNT       = 7;
   localparam int STALL_LIMIT       = 2000;
   localparam int SETTLE_CYCLES     = 50;

   typedef struct packed {
      logic                 sck;
      logic                 busy;
      logic                 done;
      logic [LCR_OUT_W-1:0] raw;
      logic [LCR_OUT_W-1:0] wgt;
      logic                 upd;
   } tick_result_type;

   class reading_scoreboard;
      phase_type                  ph;
      int unsigned                nbits;
      logic [LCR_SAMPLE_BITS-1:0] shreg;
      logic                       tare_frame;
      logic [LCR_SAMPLE_BITS-1:0] tare_raw;
      logic [LCR_SAMPLE_BITS-1:0] last_raw;
      logic [LCR_OUT_W-1:0]       last_wgt;
      logic [LCR_GAP_W-1:0]       gap;
      tick_result_type            pending_readings[$];
      int                         errors;

      function new();
         ph         = PH_IDLE;
         nbits      = 0;
         shreg      = '0;
         tare_frame = 1'b0;
         tare_raw   = '0;
         last_raw   = '0;
         last_wgt   = '0;
         gap        = LCR_GAP_RESET;
         errors     = 0;
      endfunction

      // advance the frame by one accepted tick and queue its reading
      function void note_tick(logic [1:0] f, logic d);
         tick_result_type                          r;
         logic [LCR_SAMPLE_BITS-1:0]               raw;
         logic [LCR_SAMPLE_BITS+LCR_FRAC_BITS-1:0] quot;
         r = '0;
         case (ph)
            PH_IDLE: begin
               if (f == FUNC_TARE || f == FUNC_WEIGH) begin
                  tare_frame = (f == FUNC_TARE);
                  nbits      = 0;
                  shreg      = '0;
                  ph         = PH_WAIT;
               end
            end
            PH_WAIT: begin
               if (!d) ph = PH_HIGH;
            end
            PH_HIGH: begin
               r.sck = 1'b1;
               shreg = shreg << 1;
               ph    = PH_LOW;
            end
            PH_LOW: begin
               shreg[0] = d;
               nbits++;
               ph = (nbits >= LCR_SAMPLE_BITS) ? PH_XHIGH : PH_HIGH;
            end
            PH_XHIGH: begin
               r.sck = 1'b1;
               ph    = PH_XLOW;
            end
            default: begin
               raw = shreg ^ {1'b1, {(LCR_SAMPLE_BITS-1){1'b0}}};
               if (tare_frame) begin
                  tare_raw = raw;
               end else begin
                  last_raw = raw;
                  if (raw > tare_raw) begin
                     if (gap == '0) begin
                        last_wgt = '1;
                     end else begin
                        quot = {raw - tare_raw, {LCR_FRAC_BITS{1'b0}}} / gap;
                        last_wgt = (quot > {LCR_OUT_W{1'b1}}) ? '1 : quot[LCR_OUT_W-1:0];
                     end
                     r.upd = 1'b1;
                  end
               end
               r.done = 1'b1;
               nbits  = 0;
               ph     = PH_IDLE;
            end
         endcase
         r.busy = (ph != PH_IDLE);
         r.raw  = last_raw;
         r.wgt  = last_wgt;
         pending_readings.push_back(r);
      endfunction

      function void check_reading(tick_result_type got);
         tick_result_type want;
         if (pending_readings.size() == 0) begin
            $error("result transfer with no reading pending");
            errors++;
            return;
         end
         want = pending_readings.pop_front();
         if (got.sck !== want.sck) begin
            $error("sck: expected %0d, got %0d", want.sck, got.sck);
            errors++;
         end
         if (got.busy !== want.busy) begin
            $error("busy_res: expected %0d, got %0d", want.busy, got.busy);
            errors++;
         end
         if (got.done !== want.done) begin
            $error("done_res: expected %0d, got %0d", want.done, got.done);
            errors++;
         end
         if (got.raw !== want.raw) begin
            $error("raw_value: expected %h, got %h", want.raw, got.raw);
            errors++;
         end
         if (got.wgt !== want.wgt) begin
            $error("weight: expected %h, got %h", want.wgt, got.wgt);
            errors++;
         end
         if (got.upd !== want.upd) begin
            $error("weight_updated: expected %0d, got %0d", want.upd, got.upd);
            errors++;
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [LCR_GAP_W-1:0] csr_wdata;

   lcr_req_if req_ch ();
   lcr_rsp_if rsp_ch ();

   load_cell_adc_reader_tare_scale uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_ch),
      .rsp_chan  (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   reading_scoreboard sb;
   int                ticks_sent;
   int                burst_left;
   bit                req_up;
   int                idle_cycles = 0;
   int unsigned       cyc = 0;
   int                ready_style = 0;
   int                ready_run = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // receiver: each stretch picks its own stall pattern
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         sb.check_reading('{rsp_ch.sck, rsp_ch.busy_res, rsp_ch.done_res,
                            rsp_ch.raw_value, rsp_ch.weight, rsp_ch.weight_updated});
      end
      cyc <= cyc + 1;
      if (ready_run == 0) begin
         ready_style <= $urandom_range(0, 3);
         ready_run   <= $urandom_range(20, 200);
      end else begin
         ready_run <= ready_run - 1;
      end
      case (ready_style)
         0:       rsp_ch.ready <= 1'b1;
         1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
         2:       rsp_ch.ready <= (cyc % 4 == 0);
         default: rsp_ch.ready <= (cyc % 24 == 0);
      endcase
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [1:0] random_func();
      return 2'($urandom_range(0, 3));
   endfunction

   task automatic send_tick(input logic [1:0] f, input logic d);
      req_ch.valid <= 1'b1;
      req_ch.func  <= f;
      req_ch.dout  <= d;
      req_up = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_tick(f, d);
      ticks_sent++;
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         req_up = 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                   : $urandom_range(0, 30);
      end else begin
         burst_left--;
      end
   endtask

   // word is the converter's two's complement output, msb first
   task automatic run_frame(input logic tare, input logic [LCR_SAMPLE_BITS-1:0] word,
                            input int hold_high);
      send_tick(tare ? FUNC_TARE : FUNC_WEIGH, 1'($urandom_range(0, 1)));
      repeat (hold_high) send_tick(random_func(), 1'b1);
      send_tick(random_func(), 1'b0);
      for (int i = LCR_SAMPLE_BITS - 1; i >= 0; i--) begin
         send_tick(random_func(), 1'($urandom_range(0, 1)));
         send_tick(random_func(), word[i]);
      end
      repeat (2) send_tick(random_func(), 1'($urandom_range(0, 1)));
   endtask

   task automatic drain_readings();
      if (req_up) begin
         req_ch.valid <= 1'b0;
         req_up = 1'b0;
      end
      while (sb.pending_readings.size() != 0) @(posedge clock);
   endtask

   task automatic write_gap(input logic [LCR_GAP_W-1:0] value);
      drain_readings();
      repeat (40) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.gap = value;
   endtask

   initial begin
      logic                       tare;
      logic [LCR_SAMPLE_BITS-1:0] word;
      int                         hold;
      int                         pick;

      sb           = new();
      ticks_sent   = 0;
      burst_left   = 0;
      req_up       = 1'b0;
      reset        = 1'b1;
      csr_we       = 1'b0;
      csr_wdata    = '0;
      req_ch.valid = 1'b0;
      req_ch.func  = FUNC_TICK;
      req_ch.dout  = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0:       ;
            1:       write_gap(16'd256);
            2:       write_gap(16'd65535);
            3:       write_gap(LCR_GAP_RESET);
            default: write_gap(LCR_GAP_W'($urandom_range(256, 65535)));
         endcase
         if (p == 0) begin
            // plain ticks, spare code, both data levels
            send_tick(FUNC_TICK, 1'b0);
            send_tick(FUNC_TICK, 1'b1);
            send_tick(FUNC_SPARE, 1'b0);
            send_tick(FUNC_SPARE, 1'b1);
            // tare at zero, full scale, equal to tare, tare at full scale, below tare, equal to tare
            run_frame(1'b1, 24'h800000, 0);
            run_frame(1'b0, 24'h7FFFFF, 1);
            run_frame(1'b0, 24'h800000, 0);
            run_frame(1'b1, 24'h7FFFFF, 2);
            run_frame(1'b0, 24'h7FFFFE, 0);
            run_frame(1'b0, 24'h7FFFFF, 0);
         end else if (p == 1) begin
            // a divisor of 1.0 with full span reaches the top of the weight range
            run_frame(1'b1, 24'h800000, 0);
            run_frame(1'b0, 24'h7FFFFF, 0);
         end
         while (ticks_sent < (p + 1) * TICKS_PER_PHASE) begin
            repeat ($urandom_range(0, 3))
               send_tick($urandom_range(0, 1) ? FUNC_TICK : FUNC_SPARE,
                         1'($urandom_range(0, 1)));
            tare = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 9);
            case (pick)
               0:       word = 24'h7FFFFF;
               1:       word = 24'h800000;
               2:       word = 24'h000000;
               3:       word = 24'hFFFFFF;
               default: word = LCR_SAMPLE_BITS'($urandom);
            endcase
            pick = $urandom_range(0, 19);
            if (pick == 0)     hold = $urandom_range(20, 40);   // data line held high
            else if (pick < 4) hold = $urandom_range(4, 10);
            else               hold = $urandom_range(0, 3);
            run_frame(tare, word, hold);
         end
      end

      drain_readings();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending_readings.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/lcr_pkg.sv
rtl/lcr_channels.sv
rtl/lcr_divider.sv
rtl/lcr_datapath.sv
rtl/lcr_ctrl.sv
rtl/load_cell_adc_reader_tare_scale.sv
rtl/lcr_checker.sv
tb/load_cell_adc_reader_tare_scale_tb.sv
